FILE: rtl/core/aadrc_pkg.sv
// Package for the anti-aliased disc / ring coverage shader.
// Widths, register map, item structs and shared constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package aadrc_pkg;

  // Pixel coordinate width; Q8_BITS follows from it, and the datapath widths in part.
  localparam int COORD_BITS  = 16;
  localparam int Q8_BITS     = COORD_BITS + 8;
  localparam int CFG_BITS    = 24;
  localparam int RADIUS_BITS = 23;
  localparam int COLOR_BITS  = 24;
  localparam int ALPHA_BITS  = 8;
  localparam int ARGB_BITS   = 32;

  localparam int DIFF_BITS = ((Q8_BITS > CFG_BITS) ? Q8_BITS : CFG_BITS) + 1;
  localparam int ABS_BITS  = DIFF_BITS - 1;
  localparam int SQ_BITS   = 2 * ABS_BITS;
  localparam int SUM_BITS  = SQ_BITS + 1;
  localparam int SAT_BITS  = 64;
  localparam int RAD_BITS  = (SUM_BITS > SAT_BITS) ? SAT_BITS : SUM_BITS;
  localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
  localparam int RADP_BITS = 2 * ROOT_BITS;
  localparam int COV_BITS  = ((ROOT_BITS > CFG_BITS) ? ROOT_BITS : CFG_BITS) + 3;

  // Stages: diff, abs, square, sum, one per root bit, coverage, output.
  localparam int LATENCY = ROOT_BITS + 6;

  localparam int HALF_PIXEL_Q8 = 128;
  localparam int COV_FULL      = 256;
  localparam int ALPHA_MAX     = 255;
  localparam int ALPHA_SHIFT   = 24;

  localparam logic SHAPE_DISC = 1'b0;
  localparam logic SHAPE_RING = 1'b1;

  // APB register map, one 32-bit word per register.
  localparam int IDX_BITS  = 3;
  localparam int ADDR_BITS = IDX_BITS + 2;
  localparam int DATA_BITS = 32;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_DISC_RAD   = 3'd2,
    REG_MID_RAD    = 3'd3,
    REG_HALF_WIDTH = 3'd4,
    REG_SHAPE_MODE = 3'd5,
    REG_BASE_COLOR = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic [ALPHA_BITS-1:0]        coverage_alpha;
    logic                         write_pixel;
    logic [ARGB_BITS-1:0]         argb_word;
  } pix_out_t;

  // Item tag that rides alongside the root pipeline.
  typedef struct packed {
    logic    valid;
    pix_in_t pix;
  } pix_tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/aadrc_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Carries the item tag alongside. Depends on aadrc_pkg.
`default_nettype none

module aadrc_sqrt
  import aadrc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pix_tag_t             in_tag,
  input  wire logic [RADP_BITS-1:0] in_n,
  output pix_tag_t                  out_tag,
  output logic [ROOT_BITS-1:0]      out_root
);

  localparam int REM_BITS = ROOT_BITS + 1;
  localparam int CUR_BITS = REM_BITS + 2;

  logic                 v_r    [ROOT_BITS];
  pix_in_t              pix_r  [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic [RADP_BITS-1:0] n_r    [ROOT_BITS-1];

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
    logic                 v_src;
    pix_in_t              pix_src;
    logic [REM_BITS-1:0]  rem_src;
    logic [ROOT_BITS-1:0] root_src;
    logic [RADP_BITS-1:0] n_src;
    logic [CUR_BITS-1:0]  cur_w;
    logic [CUR_BITS-1:0]  trial_w;
    logic                 take_w;

    if (s == 0) begin : g_first
      assign v_src    = in_tag.valid;
      assign pix_src  = in_tag.pix;
      assign rem_src  = '0;
      assign root_src = '0;
      assign n_src    = in_n;
    end else begin : g_next
      assign v_src    = v_r[s-1];
      assign pix_src  = pix_r[s-1];
      assign rem_src  = rem_r[s-1];
      assign root_src = root_r[s-1];
      assign n_src    = n_r[s-1];
    end

    // bring down the next radicand bit pair, try 4*root+1
    assign cur_w   = {rem_src, n_src[RADP_BITS-1 -: 2]};
    assign trial_w = CUR_BITS'({root_src, 2'b01});
    assign take_w  = (cur_w >= trial_w);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      pix_r[s]  <= pix_src;
      rem_r[s]  <= take_w ? REM_BITS'(cur_w - trial_w) : cur_w[REM_BITS-1:0];
      root_r[s] <= {root_src[ROOT_BITS-2:0], take_w};
    end

    if (s < ROOT_BITS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        n_r[s] <= n_src << 2;
      end
    end
  end

  assign out_tag.valid = v_r[ROOT_BITS-1];
  assign out_tag.pix   = pix_r[ROOT_BITS-1];
  assign out_root      = root_r[ROOT_BITS-1];

  // remainder of a floor root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tag.valid |-> (rem_r[ROOT_BITS-1] <= {root_r[ROOT_BITS-1], 1'b0}))
    else $error("sqrt remainder out of range");

  a_valid_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tag.valid |-> $past(in_tag.valid, ROOT_BITS))
    else $error("sqrt valid without matching entry");

  a_pix_carry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tag.valid |-> (out_tag.pix == $past(in_tag.pix, ROOT_BITS)))
    else $error("sqrt tag corrupted in flight");

endmodule

`default_nettype wire

FILE: rtl/core/aa_disc_ring_coverage.sv
// Top level of the anti-aliased disc / ring coverage shader.
// APB register file, distance pipeline, coverage and alpha stages.
// Depends on aadrc_pkg and aadrc_sqrt.
//
//   channel   ports                          handshake
//   --------  -----------------------------  -------------------------------
//   input     start, busy, in_data           item taken when start && !busy
//   result    out_valid, out_data            one-cycle strobe, no backpressure
//   config    psel, penable, pwrite, paddr,  APB, pready tied high,
//             pwdata, prdata, pready         write on access phase
//
// One item per clock, every clock: busy is never raised.
// The square-root pipeline resolves one root bit per stage.
// Synchronous active-low reset clears all valid bits and the config registers.
// The result side cannot stall, so nothing in the pipe ever waits.
`default_nettype none

module aa_disc_ring_coverage
  import aadrc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input items
  input  wire logic                 start,
  output logic                      busy,
  input  wire pix_in_t              in_data,
  // result items
  output logic                      out_valid,
  output pix_out_t                  out_data,
  // APB configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0]      prdata,
  output logic                      pready
);

  localparam logic signed [COV_BITS-1:0] HALF_S     = COV_BITS'(HALF_PIXEL_Q8);
  localparam logic signed [COV_BITS-1:0] COV_FULL_S = COV_BITS'(COV_FULL);

  // ---------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------
  logic signed [CFG_BITS-1:0] cx_r, cy_r, mid_r;
  logic [RADIUS_BITS-1:0]     rad_r, half_r;
  logic                       mode_r;
  logic [COLOR_BITS-1:0]      color_r;
  logic                       wr_en;
  cfg_reg_t                   reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = cfg_reg_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      rad_r   <= '0;
      mid_r   <= '0;
      half_r  <= '0;
      mode_r  <= SHAPE_DISC;
      color_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X:   cx_r    <= pwdata[CFG_BITS-1:0];
        REG_CENTER_Y:   cy_r    <= pwdata[CFG_BITS-1:0];
        REG_DISC_RAD:   rad_r   <= pwdata[RADIUS_BITS-1:0];
        REG_MID_RAD:    mid_r   <= pwdata[CFG_BITS-1:0];
        REG_HALF_WIDTH: half_r  <= pwdata[RADIUS_BITS-1:0];
        REG_SHAPE_MODE: mode_r  <= pwdata[0];
        REG_BASE_COLOR: color_r <= pwdata[COLOR_BITS-1:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X:   prdata = DATA_BITS'($unsigned(cx_r));
      REG_CENTER_Y:   prdata = DATA_BITS'($unsigned(cy_r));
      REG_DISC_RAD:   prdata = DATA_BITS'(rad_r);
      REG_MID_RAD:    prdata = DATA_BITS'($unsigned(mid_r));
      REG_HALF_WIDTH: prdata = DATA_BITS'(half_r);
      REG_SHAPE_MODE: prdata = DATA_BITS'(mode_r);
      REG_BASE_COLOR: prdata = DATA_BITS'(color_r);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Stage 1: offsets from circle center. Pixel center in Q8 is the
  // coordinate with 0x80 appended as the fraction byte.
  // ---------------------------------------------------------------
  logic                        accept_w;
  logic signed [Q8_BITS-1:0]   q8x_w, q8y_w;
  logic                        v1_r;
  pix_in_t                     pix1_r;
  logic signed [DIFF_BITS-1:0] dx_r, dy_r;

  assign accept_w = start && !busy;
  assign q8x_w    = {in_data.pixel_x, 8'(HALF_PIXEL_Q8)};
  assign q8y_w    = {in_data.pixel_y, 8'(HALF_PIXEL_Q8)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept_w;
    end
  end

  always_ff @(posedge clk) begin
    pix1_r <= in_data;
    dx_r   <= DIFF_BITS'(q8x_w) - DIFF_BITS'(cx_r);
    dy_r   <= DIFF_BITS'(q8y_w) - DIFF_BITS'(cy_r);
  end

  // ---------------------------------------------------------------
  // Stage 2: magnitudes (the most negative code cannot occur)
  // ---------------------------------------------------------------
  logic                v2_r;
  pix_in_t             pix2_r;
  logic [ABS_BITS-1:0] ax_r, ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pix2_r <= pix1_r;
    ax_r   <= dx_r[DIFF_BITS-1] ? ABS_BITS'(-dx_r) : ABS_BITS'(dx_r);
    ay_r   <= dy_r[DIFF_BITS-1] ? ABS_BITS'(-dy_r) : ABS_BITS'(dy_r);
  end

  // ---------------------------------------------------------------
  // Stage 3: squares, one multiplier per axis
  // ---------------------------------------------------------------
  logic               v3_r;
  pix_in_t            pix3_r;
  logic [SQ_BITS-1:0] sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    pix3_r <= pix2_r;
    sqx_r  <= SQ_BITS'(ax_r) * SQ_BITS'(ax_r);
    sqy_r  <= SQ_BITS'(ay_r) * SQ_BITS'(ay_r);
  end

  // ---------------------------------------------------------------
  // Stage 4: squared distance, saturating at 64 bits (only reachable
  // with the widest coordinate setting)
  // ---------------------------------------------------------------
  logic                v4_r;
  pix_in_t             pix4_r;
  logic [SAT_BITS:0]   sum_w;
  logic [SAT_BITS-1:0] sat_w;
  logic [RAD_BITS-1:0] d2_r;

  assign sum_w = (SAT_BITS+1)'(sqx_r) + (SAT_BITS+1)'(sqy_r);
  assign sat_w = sum_w[SAT_BITS] ? {SAT_BITS{1'b1}} : sum_w[SAT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pix4_r <= pix3_r;
    d2_r   <= RAD_BITS'(sat_w);
  end

  // ---------------------------------------------------------------
  // Root pipeline: ROOT_BITS stages
  // ---------------------------------------------------------------
  pix_tag_t             sq_in_tag, sq_out_tag;
  logic [ROOT_BITS-1:0] dist_w;

  assign sq_in_tag.valid = v4_r;
  assign sq_in_tag.pix   = pix4_r;

  aadrc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (sq_in_tag),
    .in_n     (RADP_BITS'(d2_r)),
    .out_tag  (sq_out_tag),
    .out_root (dist_w)
  );

  // ---------------------------------------------------------------
  // Stage 5: coverage. Disc: radius + 1/2 - dist.
  // Ring: half width + 1/2 - |dist - mid radius|.
  // ---------------------------------------------------------------
  logic                       v5_r;
  pix_in_t                    pix5_r;
  logic signed [COV_BITS-1:0] dist_s, dm_w, off_w, cov_w, cov_r;

  assign dist_s = signed'(COV_BITS'(dist_w));
  assign dm_w   = dist_s - COV_BITS'(mid_r);
  assign off_w  = dm_w[COV_BITS-1] ? -dm_w : dm_w;

  always_comb begin
    if (mode_r == SHAPE_RING) begin
      cov_w = signed'(COV_BITS'(half_r)) + HALF_S - off_w;
    end else begin
      cov_w = signed'(COV_BITS'(rad_r)) + HALF_S - dist_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= sq_out_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    pix5_r <= sq_out_tag.pix;
    cov_r  <= cov_w;
  end

  // ---------------------------------------------------------------
  // Stage 6: alpha and output register. For coverage in 1..255,
  // (cov*255)>>8 is simply cov-1.
  // ---------------------------------------------------------------
  logic [ALPHA_BITS-1:0] alpha_w;
  logic                  out_valid_r;
  pix_out_t              out_data_r;

  always_comb begin
    if (cov_r <= 0) begin
      alpha_w = '0;
    end else if (cov_r >= COV_FULL_S) begin
      alpha_w = ALPHA_BITS'(ALPHA_MAX);
    end else begin
      alpha_w = ALPHA_BITS'(cov_r - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.out_x          <= pix5_r.pixel_x;
    out_data_r.out_y          <= pix5_r.pixel_y;
    out_data_r.coverage_alpha <= alpha_w;
    out_data_r.write_pixel    <= (alpha_w != '0);
    out_data_r.argb_word      <= (ARGB_BITS'(alpha_w) << ALPHA_SHIFT)
                                 | ARGB_BITS'(color_r);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an item taken LATENCY cycles before");

  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_x == $past(in_data.pixel_x, LATENCY)) &&
                  (out_data.out_y == $past(in_data.pixel_y, LATENCY)))
    else $error("echoed coordinate does not match its item");

  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.argb_word[COLOR_BITS-1:0] == color_r))
    else $error("argb color bits differ from base color");

endmodule

`default_nettype wire
